// File: sv/bid_pkg.sv
// Shared types and widths for the 3D box overlap-ratio pipeline.
// No dependencies; every other file in the block takes names from here.
package bid_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRACTION_BITS = 16;

  // Overlap or box extent on one axis, known positive: at most 2^COORD_BITS.
  localparam int EXT_BITS   = COORD_BITS + 1;
  // Product of two extents.
  localparam int AREA_BITS  = 2 * EXT_BITS;
  // Volume: at most 2^(3*COORD_BITS).
  localparam int VOL_BITS   = 3 * COORD_BITS + 1;
  // Union: below twice the largest volume.
  localparam int UNI_BITS   = VOL_BITS + 1;
  localparam int RATIO_BITS = FRACTION_BITS + 1;

  localparam logic [RATIO_BITS-1:0] ONE_Q = RATIO_BITS'(1) << FRACTION_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_min_x;
    logic signed [COORD_BITS-1:0] a_min_y;
    logic signed [COORD_BITS-1:0] a_min_z;
    logic signed [COORD_BITS-1:0] a_max_x;
    logic signed [COORD_BITS-1:0] a_max_y;
    logic signed [COORD_BITS-1:0] a_max_z;
    logic signed [COORD_BITS-1:0] b_min_x;
    logic signed [COORD_BITS-1:0] b_min_y;
    logic signed [COORD_BITS-1:0] b_min_z;
    logic signed [COORD_BITS-1:0] b_max_x;
    logic signed [COORD_BITS-1:0] b_max_y;
    logic signed [COORD_BITS-1:0] b_max_z;
  } bid_req_t;

  typedef struct packed {
    logic [RATIO_BITS-1:0] overlap_ratio;
    logic [RATIO_BITS-1:0] overlap_distance;
    logic                  boxes_overlap;
  } bid_rsp_t;

  // Extents after the first stage: overlap (i*), box a (a*), box b (b*).
  typedef struct packed {
    logic                ovl;
    logic [EXT_BITS-1:0] ix;
    logic [EXT_BITS-1:0] iy;
    logic [EXT_BITS-1:0] iz;
    logic [EXT_BITS-1:0] ax;
    logic [EXT_BITS-1:0] ay;
    logic [EXT_BITS-1:0] az;
    logic [EXT_BITS-1:0] bx;
    logic [EXT_BITS-1:0] by;
    logic [EXT_BITS-1:0] bz;
  } bid_ext_t;

  // Dividend and divisor handed to the divider.
  typedef struct packed {
    logic                ovl;
    logic [UNI_BITS-1:0] num;
    logic [UNI_BITS-1:0] den;
  } bid_frac_t;

endpackage

// File: sv/bid_extent.sv
// First pipeline stage: per-axis overlap extents, box extents and overlap flag.
// Depends on bid_pkg.
module bid_extent (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  bid_pkg::bid_req_t req,
  output logic              vld,
  output bid_pkg::bid_ext_t ext
);

  localparam int CB = bid_pkg::COORD_BITS;
  localparam int XW = CB + 2;
  localparam int EW = bid_pkg::EXT_BITS;
  localparam logic signed [XW-1:0] ONE = XW'(1);

  function automatic logic signed [XW-1:0] box_ext(
    input logic signed [CB-1:0] lo,
    input logic signed [CB-1:0] hi
  );
    return XW'(hi) - XW'(lo) + ONE;
  endfunction

  function automatic logic signed [XW-1:0] ovl_ext(
    input logic signed [CB-1:0] alo,
    input logic signed [CB-1:0] ahi,
    input logic signed [CB-1:0] blo,
    input logic signed [CB-1:0] bhi
  );
    logic signed [CB-1:0] lo;
    logic signed [CB-1:0] hi;
    lo = (alo > blo) ? alo : blo;
    hi = (ahi < bhi) ? ahi : bhi;
    return box_ext(lo, hi);
  endfunction

  function automatic logic positive(input logic signed [XW-1:0] e);
    return !e[XW-1] && (e != '0);
  endfunction

  logic signed [XW-1:0] ex, ey, ez;
  logic signed [XW-1:0] ax_e, ay_e, az_e, bx_e, by_e, bz_e;

  always_comb begin
    ex   = ovl_ext(req.a_min_x, req.a_max_x, req.b_min_x, req.b_max_x);
    ey   = ovl_ext(req.a_min_y, req.a_max_y, req.b_min_y, req.b_max_y);
    ez   = ovl_ext(req.a_min_z, req.a_max_z, req.b_min_z, req.b_max_z);
    ax_e = box_ext(req.a_min_x, req.a_max_x);
    ay_e = box_ext(req.a_min_y, req.a_max_y);
    az_e = box_ext(req.a_min_z, req.a_max_z);
    bx_e = box_ext(req.b_min_x, req.b_max_x);
    by_e = box_ext(req.b_min_y, req.b_max_y);
    bz_e = box_ext(req.b_min_z, req.b_max_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  // Overlap extents are only meaningful when all of them are positive.
  always_ff @(posedge clk) begin
    if (en) begin
      ext.ovl <= positive(ex) && positive(ey) && positive(ez);
      ext.ix  <= ex[EW-1:0];
      ext.iy  <= ey[EW-1:0];
      ext.iz  <= ez[EW-1:0];
      ext.ax  <= ax_e[EW-1:0];
      ext.ay  <= ay_e[EW-1:0];
      ext.az  <= az_e[EW-1:0];
      ext.bx  <= bx_e[EW-1:0];
      ext.by  <= by_e[EW-1:0];
      ext.bz  <= bz_e[EW-1:0];
    end
  end

endmodule

// File: sv/bid_volume.sv
// Three stages: face areas, volumes, then union volume and dividend.
// Depends on bid_pkg.
module bid_volume (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  bid_pkg::bid_ext_t  ext,
  output logic               vld,
  output bid_pkg::bid_frac_t frac
);

  localparam int EW = bid_pkg::EXT_BITS;
  localparam int AW = bid_pkg::AREA_BITS;
  localparam int VW = bid_pkg::VOL_BITS;
  localparam int UW = bid_pkg::UNI_BITS;
  localparam int PW = AW + EW;

  // Stage A: xy areas, z extents held alongside.
  logic          vld_a, ovl_a;
  logic [AW-1:0] ia, aa, ba;
  logic [EW-1:0] iz_a, az_a, bz_a;

  // Stage B: volumes.
  logic          vld_b, ovl_b;
  logic [VW-1:0] iv, av, bv;

  logic [PW-1:0] iv_full, av_full, bv_full;

  always_comb begin
    iv_full = ia * PW'(iz_a);
    av_full = aa * PW'(az_a);
    bv_full = ba * PW'(bz_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld   <= 1'b0;
    end else if (en) begin
      vld_a <= in_vld;
      vld_b <= vld_a;
      vld   <= vld_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovl_a <= ext.ovl;
      ia    <= AW'(ext.ix) * AW'(ext.iy);
      aa    <= AW'(ext.ax) * AW'(ext.ay);
      ba    <= AW'(ext.bx) * AW'(ext.by);
      iz_a  <= ext.iz;
      az_a  <= ext.az;
      bz_a  <= ext.bz;

      ovl_b <= ovl_a;
      iv    <= iv_full[VW-1:0];
      av    <= av_full[VW-1:0];
      bv    <= bv_full[VW-1:0];

      // Intersection never exceeds either volume, so the union stays positive.
      frac.ovl <= ovl_b;
      frac.num <= UW'(iv);
      frac.den <= UW'(av) + UW'(bv) - UW'(iv);
    end
  end

endmodule

// File: sv/bid_divider.sv
// Pipelined restoring divider: one quotient bit per stage, integer bit first.
// Gives floor(num * 2^FRACTION_BITS / den) for num <= den. Depends on bid_pkg.
module bid_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  bid_pkg::bid_frac_t                frac,
  output logic                              vld,
  output logic                              ovl,
  output logic [bid_pkg::RATIO_BITS-1:0]    quo
);

  localparam int FB = bid_pkg::FRACTION_BITS;
  localparam int UW = bid_pkg::UNI_BITS;
  localparam int RB = bid_pkg::RATIO_BITS;

  logic          s_vld [0:FB];
  logic          s_ovl [0:FB];
  logic [UW-1:0] s_rem [0:FB];
  logic [UW-1:0] s_den [0:FB];
  logic [RB-1:0] s_quo [0:FB];

  // Integer bit: one only when num equals den.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld[0] <= 1'b0;
    end else if (en) begin
      s_vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_ovl[0] <= frac.ovl;
      s_den[0] <= frac.den;
      if (frac.num >= frac.den) begin
        s_rem[0] <= frac.num - frac.den;
        s_quo[0] <= RB'(1);
      end else begin
        s_rem[0] <= frac.num;
        s_quo[0] <= '0;
      end
    end
  end

  for (genvar j = 1; j <= FB; j++) begin : g_step
    logic [UW:0] shifted;
    logic [UW:0] diff;
    logic        ge;

    always_comb begin
      shifted = {s_rem[j-1], 1'b0};
      diff    = shifted - {1'b0, s_den[j-1]};
      ge      = shifted >= {1'b0, s_den[j-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s_vld[j] <= 1'b0;
      end else if (en) begin
        s_vld[j] <= s_vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_ovl[j] <= s_ovl[j-1];
        s_den[j] <= s_den[j-1];
        s_rem[j] <= ge ? diff[UW-1:0] : shifted[UW-1:0];
        s_quo[j] <= {s_quo[j-1][RB-2:0], ge};
      end
    end
  end

  assign vld = s_vld[FB];
  assign ovl = s_ovl[FB];
  assign quo = s_quo[FB];

endmodule

// File: sv/box_iou_distance_3d.sv
// Top level: intersection over union of two axis-aligned 3D boxes, as Q16 fractions.
// Depends on bid_pkg, bid_extent, bid_volume and bid_divider.
//
//   Port group    Direction   Carries
//   req / _valid  in          two boxes, inclusive integer min and max corners
//   rsp / _valid  out         overlap ratio, overlap distance, overlap flag
//
// One request enters per cycle and one response leaves per cycle while rsp is not stalled.
// The pipeline is one extent stage, three volume stages, FRACTION_BITS + 1 divider
// stages (one quotient bit each) and the response register. The divider chain sets
// the depth.
// Reset clears every valid bit; payload registers are left as they are.
// All stages advance together when the response register is empty or being taken,
// so a stall on rsp holds every request in place and drops none.
module box_iou_distance_3d (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bid_pkg::bid_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bid_pkg::bid_rsp_t rsp
);

  localparam int RB = bid_pkg::RATIO_BITS;

  // Pipeline advance: the response register is free or is being emptied.
  logic en;
  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  logic               ext_vld;
  bid_pkg::bid_ext_t  ext;
  logic               frac_vld;
  bid_pkg::bid_frac_t frac;
  logic               div_vld;
  logic               div_ovl;
  logic [RB-1:0]      div_quo;
  logic [RB-1:0]      ratio_next;

  // Stage 1: overlap and box extents per axis.
  bid_extent u_extent (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (req_valid),
    .req    (req),
    .vld    (ext_vld),
    .ext    (ext)
  );

  // Stages 2 to 4: areas, volumes, union.
  bid_volume u_volume (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (ext_vld),
    .ext    (ext),
    .vld    (frac_vld),
    .frac   (frac)
  );

  // Quotient bits, most significant first.
  bid_divider u_divider (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (frac_vld),
    .frac   (frac),
    .vld    (div_vld),
    .ovl    (div_ovl),
    .quo    (div_quo)
  );

  // Disjoint boxes: drop the quotient, which came from meaningless volumes.
  assign ratio_next = div_ovl ? div_quo : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.overlap_ratio    <= ratio_next;
      rsp.overlap_distance <= bid_pkg::ONE_Q - ratio_next;
      rsp.boxes_overlap    <= div_ovl;
    end
  end

  // Ratio and distance always add up to one.
  a_sum_one: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ({1'b0, rsp.overlap_ratio} + {1'b0, rsp.overlap_distance})
                  == {1'b0, bid_pkg::ONE_Q})
    else $error("ratio and distance do not sum to one");

  // Disjoint boxes give a zero ratio.
  a_disjoint_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.boxes_overlap |-> rsp.overlap_ratio == '0)
    else $error("non-zero ratio for disjoint boxes");

  // The intersection never exceeds the union, so the quotient never exceeds one.
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    div_vld && div_ovl |-> div_quo <= bid_pkg::ONE_Q)
    else $error("quotient above one");

  // An empty response register always lets a request in.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request blocked while response register is empty");

endmodule
